// File: rtl/core/a64c_pkg.sv
`default_nettype none

package a64c_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE    = 1'd1;

	// result operation class
	typedef enum logic [3:0] {
		OP_MOVZ = 4'd0,
		OP_MOVK = 4'd1,
		OP_ADDI = 4'd2,
		OP_SUBI = 4'd3,
		OP_ADDR = 4'd4,
		OP_SUBR = 4'd5,
		OP_LDR  = 4'd6,
		OP_STR  = 4'd7,
		OP_CBZ  = 4'd8,
		OP_CBNZ = 4'd9,
		OP_B    = 4'd10,
		OP_NOP  = 4'd11,
		OP_HLT  = 4'd12,
		OP_STOP = 4'd13
	} op_class_t;

	// stop status codes
	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_FETCH   = 3'd1,
		ST_UNDEF   = 3'd2,
		ST_PRIV    = 3'd3,
		ST_SYSREG  = 3'd4,
		ST_HALT    = 3'd5
	} stop_status_t;

	// coarse decode group found in the first stage
	typedef enum logic [3:0] {
		K_ABORT = 4'd0,
		K_MOV   = 4'd1,
		K_ADDI  = 4'd2,
		K_ADDR  = 4'd3,
		K_LDST  = 4'd4,
		K_CB    = 4'd5,
		K_B     = 4'd6,
		K_NOP   = 4'd7,
		K_HLT   = 4'd8,
		K_PRIV  = 4'd9,
		K_SYS   = 4'd10,
		K_UNDEF = 4'd11
	} kind_t;

	// encoding masks and match values
	localparam logic [31:0] MOV_MASK    = 32'h7f80_0000;
	localparam logic [31:0] MOVZ_VAL    = 32'h5280_0000;
	localparam logic [31:0] MOVK_VAL    = 32'h7280_0000;
	localparam logic [31:0] ADDI_MASK   = 32'h3f80_0000;
	localparam logic [31:0] ADDI_VAL    = 32'h1100_0000;
	localparam logic [31:0] ADDR_MASK   = 32'h3fe0_fc00;
	localparam logic [31:0] ADDR_VAL    = 32'h0b00_0000;
	localparam logic [31:0] LDST_MASK   = 32'hffc0_0000;
	localparam logic [31:0] STR_VAL     = 32'hf900_0000;
	localparam logic [31:0] LDR_VAL     = 32'hf940_0000;
	localparam logic [31:0] CB_MASK     = 32'h7e00_0000;
	localparam logic [31:0] CB_VAL      = 32'h3400_0000;
	localparam logic [31:0] B_MASK      = 32'hfc00_0000;
	localparam logic [31:0] B_VAL       = 32'h1400_0000;
	localparam logic [31:0] NOP_WORD    = 32'hd503_201f;
	localparam logic [31:0] HLT_WORD    = 32'hd440_0000;
	localparam logic [31:0] ERET_WORD   = 32'hd69f_03e0;
	localparam logic [31:0] ERETAA_WORD = 32'hd69f_0be0;
	localparam logic [31:0] ERETAB_WORD = 32'hd69f_0fe0;
	localparam logic [31:0] WFI_WORD    = 32'hd503_207f;
	localparam logic [31:0] WFE_WORD    = 32'hd503_205f;
	localparam logic [31:0] EXC_MASK    = 32'hffe0_001f;
	localparam logic [31:0] HVC_VAL     = 32'hd400_0002;
	localparam logic [31:0] SMC_VAL     = 32'hd400_0003;
	localparam logic [31:0] MSRI_MASK   = 32'hffff_f0ff;
	localparam logic [31:0] MSRI_A_VAL  = 32'hd503_40df;
	localparam logic [31:0] MSRI_B_VAL  = 32'hd503_409f;
	localparam logic [31:0] SYSHI_MASK  = 32'hffe0_0000;
	localparam logic [31:0] MRS_HI_VAL  = 32'hd520_0000;
	localparam logic [31:0] MSR_HI_VAL  = 32'hd500_0000;
	localparam logic [31:0] SYS_MASK    = 32'hffc0_0000;
	localparam logic [31:0] SYS_VAL     = 32'hd500_0000;

	// system registers that only el1 and above may touch
	function automatic logic el1_only_key(input logic [14:0] key);
		logic hit;
		case (key)
			15'h4038, 15'h4031, 15'h4080, 15'h4100, 15'h4101, 15'h4102,
			15'h4510, 15'h4600, 15'h4290, 15'h4300, 15'h4201, 15'h4200: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/a64_subset_instruction_classifier.sv
`default_nettype none

// A64 subset instruction classifier. Takes one instruction word and its fetch
// address per request and returns one decoded request: operation class, stop
// status, register numbers, width, immediate and branch target. A new request
// is taken every cycle while out_ready does not stall the pipe; the stages are:
// stage 1 does the fetch bounds compare against image_size and the coarse
// decode, stage 2 builds the per-class fields, stage 3 holds the 64-bit branch
// target adder and is the output register. Backpressure on out_ready stalls
// the pipe in place without loss, though empty stages still fill. current_level
// and image_size are written through the cfg channel (index 0 and 1), which
// is always ready; they should only change while no request is in flight.
module a64_subset_instruction_classifier (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [a64c_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [63:0]                      cfg_data,
	// instruction request channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [31:0]                      instr_word,
	input  wire logic [63:0]                      fetch_pc,
	// decoded request channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [3:0]                            op_class,
	output logic [2:0]                            stop_status,
	output logic                                  is_wide,
	output logic [4:0]                            dest_reg,
	output logic [4:0]                            src_reg_a,
	output logic [4:0]                            src_reg_b,
	output logic [63:0]                           imm_value,
	output logic [5:0]                            move_shift,
	output logic [63:0]                           target_pc,
	output logic                                  ends_block
);
	import a64c_pkg::*;

	// configuration registers
	logic [1:0]  current_level_q;
	logic [63:0] image_size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_level_q <= 2'd0;
			image_size_q    <= 64'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CURRENT_LEVEL: current_level_q <= cfg_data[1:0];
				CFG_IMAGE_SIZE:    image_size_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control: a stage moves when the next one is empty or moving
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: fetch check and coarse decode on the incoming word
	// ---------------------------------------------------------------
	logic        at_el0;
	logic        fetch_bad;
	logic        is_eret;
	logic        priv_word;
	logic        mov_hit;
	kind_t       kind_d;

	assign at_el0 = (current_level_q == 2'd0);

	// misaligned, image under one word, past the end, or pc + 4 wrapping
	assign fetch_bad = (fetch_pc[1:0] != 2'd0) || (image_size_q < 64'd4) ||
		(fetch_pc > (image_size_q - 64'd4)) || (&fetch_pc[63:2]);

	assign is_eret = (instr_word == ERET_WORD) || (instr_word == ERETAA_WORD) ||
		(instr_word == ERETAB_WORD);

	assign priv_word = at_el0 && (is_eret ||
		(instr_word == WFI_WORD) || (instr_word == WFE_WORD) ||
		((instr_word & EXC_MASK) == HVC_VAL) || ((instr_word & EXC_MASK) == SMC_VAL) ||
		((instr_word & MSRI_MASK) == MSRI_A_VAL) || ((instr_word & MSRI_MASK) == MSRI_B_VAL) ||
		((((instr_word & SYSHI_MASK) == MRS_HI_VAL) ||
		  ((instr_word & SYSHI_MASK) == MSR_HI_VAL)) && el1_only_key(instr_word[19:5])));

	assign mov_hit = ((instr_word & MOV_MASK) == MOVZ_VAL) ||
		((instr_word & MOV_MASK) == MOVK_VAL);

	always_comb begin
		if (fetch_bad) begin
			kind_d = K_ABORT;
		end else if (mov_hit) begin
			// narrow move with hw of 2 or 3 is undefined
			kind_d = (!instr_word[31] && instr_word[22]) ? K_UNDEF : K_MOV;
		end else if ((instr_word & ADDI_MASK) == ADDI_VAL) begin
			kind_d = K_ADDI;
		end else if ((instr_word & ADDR_MASK) == ADDR_VAL) begin
			kind_d = K_ADDR;
		end else if (((instr_word & LDST_MASK) == STR_VAL) ||
			((instr_word & LDST_MASK) == LDR_VAL)) begin
			kind_d = K_LDST;
		end else if ((instr_word & CB_MASK) == CB_VAL) begin
			kind_d = K_CB;
		end else if ((instr_word & B_MASK) == B_VAL) begin
			kind_d = K_B;
		end else if (instr_word == NOP_WORD) begin
			kind_d = K_NOP;
		end else if (instr_word == HLT_WORD) begin
			kind_d = K_HLT;
		end else if (priv_word) begin
			kind_d = K_PRIV;
		end else if (is_eret || ((instr_word & SYS_MASK) == SYS_VAL)) begin
			kind_d = K_SYS;
		end else begin
			kind_d = K_UNDEF;
		end
	end

	kind_t       kind_s1;
	logic [31:0] word_s1;
	logic [63:0] pc_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= kind_d;
			word_s1 <= instr_word;
			pc_s1   <= fetch_pc;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: per-class field build
	// ---------------------------------------------------------------
	op_class_t    cls_d;
	stop_status_t st_d;
	logic         wide_d;
	logic [4:0]   rd_d, rn_d, rm_d;
	logic [63:0]  imm_d;
	logic [5:0]   sh_d;
	logic [63:0]  ofs_d;
	logic         ends_d;

	always_comb begin
		cls_d  = OP_STOP;
		st_d   = ST_NONE;
		wide_d = 1'b0;
		rd_d   = 5'd0;
		rn_d   = 5'd0;
		rm_d   = 5'd0;
		imm_d  = 64'd0;
		sh_d   = 6'd0;
		ofs_d  = 64'd0;
		ends_d = 1'b1;
		case (kind_s1)
			K_ABORT: st_d = ST_FETCH;
			K_MOV: begin
				cls_d  = word_s1[29] ? OP_MOVK : OP_MOVZ;
				wide_d = word_s1[31];
				rd_d   = word_s1[4:0];
				sh_d   = {word_s1[22:21], 4'd0};
				imm_d  = {48'd0, word_s1[20:5]} << sh_d;
				ends_d = 1'b0;
			end
			K_ADDI: begin
				cls_d  = word_s1[30] ? OP_SUBI : OP_ADDI;
				wide_d = word_s1[31];
				rd_d   = word_s1[4:0];
				rn_d   = word_s1[9:5];
				imm_d  = word_s1[22] ? {40'd0, word_s1[21:10], 12'd0}
				                     : {52'd0, word_s1[21:10]};
				ends_d = 1'b0;
			end
			K_ADDR: begin
				cls_d  = word_s1[30] ? OP_SUBR : OP_ADDR;
				wide_d = word_s1[31];
				rd_d   = word_s1[4:0];
				rn_d   = word_s1[9:5];
				rm_d   = word_s1[20:16];
				ends_d = 1'b0;
			end
			K_LDST: begin
				cls_d  = word_s1[22] ? OP_LDR : OP_STR;
				wide_d = 1'b1;
				rd_d   = word_s1[4:0];
				rn_d   = word_s1[9:5];
				imm_d  = {49'd0, word_s1[21:10], 3'd0};
				ends_d = 1'b0;
			end
			K_CB: begin
				cls_d  = word_s1[24] ? OP_CBNZ : OP_CBZ;
				wide_d = word_s1[31];
				rd_d   = word_s1[4:0];
				ofs_d  = {{43{word_s1[23]}}, word_s1[23:5], 2'd0};
			end
			K_B: begin
				cls_d = OP_B;
				ofs_d = {{36{word_s1[25]}}, word_s1[25:0], 2'd0};
			end
			K_NOP: begin
				cls_d  = OP_NOP;
				ends_d = 1'b0;
			end
			K_HLT: begin
				cls_d = OP_HLT;
				st_d  = ST_HALT;
			end
			K_PRIV:  st_d = ST_PRIV;
			K_SYS:   st_d = ST_SYSREG;
			K_UNDEF: st_d = ST_UNDEF;
			default: st_d = ST_UNDEF;
		endcase
	end

	op_class_t    cls_s2;
	stop_status_t st_s2;
	logic         wide_s2;
	logic [4:0]   rd_s2, rn_s2, rm_s2;
	logic [63:0]  imm_s2;
	logic [5:0]   sh_s2;
	logic [63:0]  ofs_s2;
	logic [63:0]  pc_s2;
	logic         ends_s2;
	logic         branch_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			cls_s2    <= cls_d;
			st_s2     <= st_d;
			wide_s2   <= wide_d;
			rd_s2     <= rd_d;
			rn_s2     <= rn_d;
			rm_s2     <= rm_d;
			imm_s2    <= imm_d;
			sh_s2     <= sh_d;
			ofs_s2    <= ofs_d;
			pc_s2     <= pc_s1;
			ends_s2   <= ends_d;
			branch_s2 <= (kind_s1 == K_CB) || (kind_s1 == K_B);
		end
	end

	// ---------------------------------------------------------------
	// stage 3: branch target add, output register
	// ---------------------------------------------------------------
	op_class_t    cls_s3;
	stop_status_t st_s3;
	logic         wide_s3;
	logic [4:0]   rd_s3, rn_s3, rm_s3;
	logic [63:0]  imm_s3;
	logic [5:0]   sh_s3;
	logic [63:0]  tgt_s3;
	logic         ends_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			cls_s3  <= cls_s2;
			st_s3   <= st_s2;
			wide_s3 <= wide_s2;
			rd_s3   <= rd_s2;
			rn_s3   <= rn_s2;
			rm_s3   <= rm_s2;
			imm_s3  <= imm_s2;
			sh_s3   <= sh_s2;
			// target wraps modulo 2^64; zero for non-branches
			tgt_s3  <= branch_s2 ? (pc_s2 + ofs_s2) : 64'd0;
			ends_s3 <= ends_s2;
		end
	end

	assign out_valid   = v_s3;
	assign op_class    = cls_s3;
	assign stop_status = st_s3;
	assign is_wide     = wide_s3;
	assign dest_reg    = rd_s3;
	assign src_reg_a   = rn_s3;
	assign src_reg_b   = rm_s3;
	assign imm_value   = imm_s3;
	assign move_shift  = sh_s3;
	assign target_pc   = tgt_s3;
	assign ends_block  = ends_s3;

endmodule

`default_nettype wire

// File: tb/sv/a64c_decode_check_pkg.sv
`default_nettype none

package a64c_decode_check_pkg;

	import a64c_pkg::*;

	// one decoded request, laid out in port order
	typedef struct packed {
		op_class_t    op;
		stop_status_t status;
		logic         wide;
		logic [4:0]   rd;
		logic [4:0]   rn;
		logic [4:0]   rm;
		logic [63:0]  imm;
		logic [5:0]   shift;
		logic [63:0]  target;
		logic         ends;
	} decoded_t;

	// op0/op1/crn/crm/op2 keys of registers that el0 may not touch
	localparam logic [14:0] EL1_SYSREG_KEYS [12] = '{
		15'h4038, 15'h4031, 15'h4080, 15'h4100, 15'h4101, 15'h4102,
		15'h4510, 15'h4600, 15'h4290, 15'h4300, 15'h4201, 15'h4200
	};

	function automatic logic exc_return(input logic [31:0] w);
		return w == ERET_WORD || w == ERETAA_WORD || w == ERETAB_WORD;
	endfunction

	function automatic logic el0_forbidden(input logic [31:0] w);
		logic hit;
		hit = exc_return(w) || w == WFI_WORD || w == WFE_WORD ||
			(w & EXC_MASK) == HVC_VAL || (w & EXC_MASK) == SMC_VAL ||
			(w & MSRI_MASK) == MSRI_A_VAL || (w & MSRI_MASK) == MSRI_B_VAL;
		if ((w & SYSHI_MASK) == MRS_HI_VAL || (w & SYSHI_MASK) == MSR_HI_VAL) begin
			foreach (EL1_SYSREG_KEYS[i])
				if (w[19:5] == EL1_SYSREG_KEYS[i])
					hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic decoded_t predict_decode(input logic [31:0] w, input logic [63:0] pc,
			input logic [1:0] level, input logic [63:0] image_bytes);
		decoded_t r;
		logic [5:0] pos;
		r = '0;
		r.op = OP_STOP;
		pos = {w[22:21], 4'b0000};
		if (pc[1:0] != 2'b00 || image_bytes < 64'd4 || pc > image_bytes - 64'd4 ||
				pc > 64'hffff_ffff_ffff_fffb) begin
			r.status = ST_FETCH;
		end else if ((w & MOV_MASK) == MOVZ_VAL || (w & MOV_MASK) == MOVK_VAL) begin
			if (!w[31] && w[22]) begin
				r.status = ST_UNDEF;
			end else begin
				r.op = ((w & MOV_MASK) == MOVK_VAL) ? OP_MOVK : OP_MOVZ;
				r.wide = w[31];
				r.rd = w[4:0];
				r.imm = {48'd0, w[20:5]} << pos;
				r.shift = pos;
			end
		end else if ((w & ADDI_MASK) == ADDI_VAL) begin
			r.op = w[30] ? OP_SUBI : OP_ADDI;
			r.wide = w[31];
			r.rd = w[4:0];
			r.rn = w[9:5];
			r.imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
		end else if ((w & ADDR_MASK) == ADDR_VAL) begin
			r.op = w[30] ? OP_SUBR : OP_ADDR;
			r.wide = w[31];
			r.rd = w[4:0];
			r.rn = w[9:5];
			r.rm = w[20:16];
		end else if ((w & LDST_MASK) == STR_VAL || (w & LDST_MASK) == LDR_VAL) begin
			r.op = w[22] ? OP_LDR : OP_STR;
			r.wide = 1'b1;
			r.rd = w[4:0];
			r.rn = w[9:5];
			r.imm = {49'd0, w[21:10], 3'd0};
		end else if ((w & CB_MASK) == CB_VAL) begin
			r.op = w[24] ? OP_CBNZ : OP_CBZ;
			r.wide = w[31];
			r.rd = w[4:0];
			r.target = pc + {{43{w[23]}}, w[23:5], 2'b00};
			r.ends = 1'b1;
		end else if ((w & B_MASK) == B_VAL) begin
			r.op = OP_B;
			r.target = pc + {{36{w[25]}}, w[25:0], 2'b00};
			r.ends = 1'b1;
		end else if (w == NOP_WORD) begin
			r.op = OP_NOP;
		end else if (w == HLT_WORD) begin
			r.op = OP_HLT;
			r.status = ST_HALT;
			r.ends = 1'b1;
		end else if (level == 2'd0 && el0_forbidden(w)) begin
			r.status = ST_PRIV;
		end else if (exc_return(w) || (w & SYS_MASK) == SYS_VAL) begin
			r.status = ST_SYSREG;
		end else begin
			r.status = ST_UNDEF;
		end
		if (r.op == OP_STOP)
			r.ends = 1'b1;
		return r;
	endfunction

	class decode_scoreboard;
		logic [1:0]  level = 2'd0;
		logic [63:0] image_bytes = 64'd0;
		decoded_t    pending[$];
		int unsigned checked = 0;
		int unsigned errors = 0;
		int unsigned class_hits[16];

		function void note_fetch(input logic [31:0] w, input logic [63:0] pc);
			pending.push_back(predict_decode(w, pc, level, image_bytes));
		endfunction

		function void report(input string field, input logic [63:0] want, input logic [63:0] got);
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		endfunction

		function void check_decode(input decoded_t got);
			decoded_t want;
			if (pending.size() == 0) begin
				$error("decoded request with none outstanding, op_class 0x%0h", got.op);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			class_hits[want.op]++;
			if (got.op !== want.op)
				report("op_class", 64'(want.op), 64'(got.op));
			if (got.status !== want.status)
				report("stop_status", 64'(want.status), 64'(got.status));
			if (got.wide !== want.wide)
				report("is_wide", 64'(want.wide), 64'(got.wide));
			if (got.rd !== want.rd)
				report("dest_reg", 64'(want.rd), 64'(got.rd));
			if (got.rn !== want.rn)
				report("src_reg_a", 64'(want.rn), 64'(got.rn));
			if (got.rm !== want.rm)
				report("src_reg_b", 64'(want.rm), 64'(got.rm));
			if (got.imm !== want.imm)
				report("imm_value", want.imm, got.imm);
			if (got.shift !== want.shift)
				report("move_shift", 64'(want.shift), 64'(got.shift));
			if (got.target !== want.target)
				report("target_pc", want.target, got.target);
			if (got.ends !== want.ends)
				report("ends_block", 64'(want.ends), 64'(got.ends));
		endfunction
	endclass

endpackage

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;

	import a64c_pkg::*;
	import a64c_decode_check_pkg::*;

	// run limits
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned LONG_HOLD   = 200;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// config write channel
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CURRENT_LEVEL;
	logic [63:0]          cfg_data  = 64'd0;

	// fetch request channel
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [31:0] instr_word = 32'd0;
	logic [63:0] fetch_pc   = 64'd0;

	// decoded request channel
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  op_class;
	logic [2:0]  stop_status;
	logic        is_wide;
	logic [4:0]  dest_reg;
	logic [4:0]  src_reg_a;
	logic [4:0]  src_reg_b;
	logic [63:0] imm_value;
	logic [5:0]  move_shift;
	logic [63:0] target_pc;
	logic        ends_block;

	decode_scoreboard sb;
	decoded_t         seen;

	// sender burst state
	int unsigned burst_left = 0;
	int unsigned settings   = 0;
	int unsigned directed   = 0;

	// receiver stall state, owned by the receiver process
	int unsigned hold_left     = 0;
	int unsigned pattern_age   = 0;
	logic [7:0]  ready_pattern = 8'hff;
	logic        hold_done     = 1'b0;

	int unsigned cycles = 0;

	// end-of-run summary
	string      mix;
	op_class_t  oc;

	a64_subset_instruction_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.instr_word  (instr_word),
		.fetch_pc    (fetch_pc),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.op_class    (op_class),
		.stop_status (stop_status),
		.is_wide     (is_wide),
		.dest_reg    (dest_reg),
		.src_reg_a   (src_reg_a),
		.src_reg_b   (src_reg_b),
		.imm_value   (imm_value),
		.move_shift  (move_shift),
		.target_pc   (target_pc),
		.ends_block  (ends_block)
	);

	always #1 clk = ~clk;

	// output ports gathered in struct order
	assign seen = {op_class, stop_status, is_wide, dest_reg, src_reg_a, src_reg_b,
		imm_value, move_shift, target_pc, ends_block};

	// every accepted decoded request goes straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_decode(seen);
	end

	// receiver: one long hold-off early on so the pipe backs up into in_ready,
	// otherwise a rotating ready pattern, reloaded once its random age runs out
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && sb.checked >= 100) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(16, 64);
				case ($urandom_range(0, 3))
					0: ready_pattern = 8'hff;          // no stalls at all
					1: ready_pattern = 8'($urandom_range(1, 255));
					2: ready_pattern = 8'h11;          // ready a quarter of the time
					default: ready_pattern = 8'hef;
				endcase
			end
			pattern_age--;
			out_ready <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests outstanding", cycles,
				sb.pending.size());
			$display("** a64_subset_instruction_classifier: FAILED **");
			$finish;
		end
	end

	// offer one fetch request; a new burst may start with a gap of idle cycles
	task automatic send_fetch(input logic [31:0] w, input logic [63:0] pc);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		instr_word <= w;
		fetch_pc   <= pc;
		do @(posedge clk); while (!in_ready);
		sb.note_fetch(w, pc);
		burst_left--;
	endtask

	// stop offering and wait for every outstanding request to come back
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic await_cfg();
		do @(posedge clk); while (!cfg_ready);
	endtask

	// both registers written back to back while the pipe is empty
	task automatic set_decode_regs(input logic [1:0] level, input logic [63:0] image_bytes);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CURRENT_LEVEL;
		cfg_data  <= {62'd0, level};
		await_cfg();
		sb.level = level;
		cfg_index <= CFG_IMAGE_SIZE;
		cfg_data  <= image_bytes;
		await_cfg();
		sb.image_bytes = image_bytes;
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// mostly well-formed encodings of each class with random fields, plus
	// privileged and system-space words and some plain noise
	function automatic logic [31:0] random_word();
		logic [31:0] r;
		logic [31:0] w;
		int unsigned pick;
		r = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 14)
			w = ($urandom_range(0, 1) ? MOVK_VAL : MOVZ_VAL) | (r & ~MOV_MASK);
		else if (pick < 26)
			w = ADDI_VAL | (r & ~ADDI_MASK);
		else if (pick < 36)
			w = ADDR_VAL | (r & ~ADDR_MASK);
		else if (pick < 48)
			w = ($urandom_range(0, 1) ? LDR_VAL : STR_VAL) | (r & ~LDST_MASK);
		else if (pick < 58)
			w = CB_VAL | (r & ~CB_MASK);
		else if (pick < 66)
			w = B_VAL | (r & ~B_MASK);
		else if (pick < 70)
			w = $urandom_range(0, 1) ? NOP_WORD : HLT_WORD;
		else if (pick < 76) begin
			case ($urandom_range(0, 4))
				0: w = ERET_WORD;
				1: w = ERETAA_WORD;
				2: w = ERETAB_WORD;
				3: w = WFI_WORD;
				default: w = WFE_WORD;
			endcase
		end else if (pick < 80)
			w = ($urandom_range(0, 1) ? HVC_VAL : SMC_VAL) | (r & ~EXC_MASK);
		else if (pick < 84)
			w = ($urandom_range(0, 1) ? MSRI_A_VAL : MSRI_B_VAL) | (r & ~MSRI_MASK);
		else if (pick < 90) begin
			// mrs/msr, usually naming one of the el1-only registers
			w = ($urandom_range(0, 1) ? MRS_HI_VAL : MSR_HI_VAL) | (r & ~SYSHI_MASK);
			if ($urandom_range(0, 2) != 0)
				w[19:5] = EL1_SYSREG_KEYS[$urandom_range(0, 11)];
		end else if (pick < 94)
			w = SYS_VAL | (r & ~SYS_MASK);
		else
			w = r;
		return w;
	endfunction

	// mostly aligned addresses inside the image, with its edges and some wild ones
	function automatic logic [63:0] pick_pc(input logic [63:0] image_bytes);
		logic [63:0] raw;
		logic [63:0] pc;
		raw = {$urandom, $urandom};
		if (image_bytes < 64'd4 || $urandom_range(0, 9) == 0) begin
			pc = raw;
		end else begin
			case ($urandom_range(0, 15))
				0: pc = (image_bytes - 64'd4) & ~64'd3;   // last word of the image
				1: pc = 64'd0;
				2: pc = image_bytes - 64'd3;              // just past the end
				default: pc = (raw % (image_bytes - 64'd3)) & ~64'd3;
			endcase
		end
		return pc;
	endfunction

	task automatic run_random(input int unsigned n, input int unsigned pause_at);
		for (int unsigned i = 0; i < n; i++) begin
			// sender pause: let the pipe run dry before going on
			if (i == pause_at)
				drain();
			send_fetch(random_word(), pick_pc(sb.image_bytes));
		end
	endtask

	task automatic send_directed(input logic [31:0] w, input logic [63:0] pc);
		send_fetch(w, pc);
		directed++;
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: empty image, every fetch aborts
		run_random(4, 0);

		// directed requests at el0 in a 64 KiB image
		set_decode_regs(2'd0, 64'h1_0000);
		send_directed(32'hd2ff_ffff, 64'h0);          // movz x31, #0xffff, lsl 48
		send_directed(32'h72a2_4685, 64'h4);          // movk w5, #0x1234, lsl 16
		send_directed(32'h52c0_0009, 64'h8);          // 32-bit move with shift 32
		send_directed(32'h917f_ffff, 64'hc);          // add sp, sp, #0xfff, lsl 12
		send_directed(32'h5100_0441, 64'h10);         // sub w1, w2, #1
		send_directed(32'h8b1f_03ff, 64'h14);         // add register, all 31
		send_directed(32'h4b02_0020, 64'h18);         // sub w0, w1, w2
		send_directed(32'hf97f_ffff, 64'h1c);         // ldr with largest offset
		send_directed(32'hf900_0000, 64'h20);         // str x0, [x0]
		send_directed(32'hb480_0000, 64'h0);          // cbz backward, target wraps
		send_directed(32'h357f_ffe3, 64'hfffc);       // cbnz forward max
		send_directed(32'h1600_0000, 64'h100);        // b backward max
		send_directed(32'h15ff_ffff, 64'h0);          // b forward max
		send_directed(NOP_WORD, 64'h24);
		send_directed(HLT_WORD, 64'h28);
		send_directed(ERET_WORD, 64'h2c);             // eret at el0
		send_directed(WFI_WORD, 64'h30);
		send_directed(32'hd400_0022, 64'h34);         // hvc #1
		send_directed(32'hd503_41df, 64'h38);         // msr immediate, crm 1
		send_directed(MRS_HI_VAL | 32'h0008_1000, 64'h3c);  // mrs of sctlr_el1
		send_directed(MRS_HI_VAL | 32'h000b_d040, 64'h40);  // mrs of an el0 register
		send_directed(32'h0000_0000, 64'h44);         // plain undefined
		send_directed(NOP_WORD, 64'h2);               // misaligned fetch
		send_directed(NOP_WORD, 64'hfffc);            // last word of the image
		send_directed(NOP_WORD, 64'hffff_ffff_ffff_fffc);  // pc + 4 wraps

		// whole address space as image; long output hold-off lands in here
		set_decode_regs(2'd0, 64'hffff_ffff_ffff_ffff);
		run_random(320, 160);

		// smallest usable image at el1: exception return and hvc change meaning
		set_decode_regs(2'd1, 64'd4);
		send_directed(ERET_WORD, 64'h0);
		send_directed(32'hd400_0022, 64'h0);
		send_directed(WFI_WORD, 64'h0);
		run_random(40, 0);

		set_decode_regs(2'd3, {$urandom, $urandom});
		run_random(280, 0);

		// image one byte too small for any fetch
		set_decode_regs(2'd2, 64'd3);
		run_random(16, 0);

		set_decode_regs(2'd0, {32'd0, $urandom} | 64'h100);
		run_random(270, 0);

		drain();
		repeat (8) @(posedge clk);

		mix = "";
		for (int k = 0; k <= OP_STOP; k++) begin
			oc = op_class_t'(k);
			mix = {mix, $sformatf(" %s=%0d", oc.name(), sb.class_hits[k])};
		end
		$display("decoded %0d requests (%0d directed) over %0d register settings, el0 and above,",
			sb.checked, directed, settings);
		$display("image sizes from empty to full range, %0d-cycle output hold-off; classes:%s",
			LONG_HOLD, mix);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("** a64_subset_instruction_classifier: PASSED **");
		end else begin
			$display("** a64_subset_instruction_classifier: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: a64_subset_instruction_classifier.f
rtl/core/a64c_pkg.sv
rtl/core/a64_subset_instruction_classifier.sv
tb/sv/a64c_decode_check_pkg.sv
tb/sv/tb_top.sv
